/* sv/cau_pkg.sv */
// package for the complex arithmetic unit: widths, codes, types, tables, helpers
`default_nettype none
package cau_pkg;

    // operand format
    localparam int DATA_W = 16;
    localparam int FRAC_W = 12;

    // unit sizes
    localparam int CORDIC_N = 30;
    localparam int SQRT_N   = DATA_W;
    localparam int DIV_N    = DATA_W + FRAC_W + 1;

    // stage numbers in the pipeline
    localparam int ST_MUL    = 3;
    localparam int ST_SQRT   = ST_MUL + SQRT_N;
    localparam int ST_CORDIC = 2 + CORDIC_N;
    localparam int ST_LAST   = ST_MUL + DIV_N + 1;

    // command codes
    localparam logic [2:0] CMD_ADD   = 3'd0;
    localparam logic [2:0] CMD_SUB   = 3'd1;
    localparam logic [2:0] CMD_MUL   = 3'd2;
    localparam logic [2:0] CMD_DIV   = 3'd3;
    localparam logic [2:0] CMD_MAG   = 3'd4;
    localparam logic [2:0] CMD_PHASE = 3'd5;

    // status codes
    localparam logic [1:0] STAT_OK  = 2'd0;
    localparam logic [1:0] STAT_SAT = 2'd1;
    localparam logic [1:0] STAT_DZ  = 2'd2;

    // pi in Q30
    localparam logic signed [34:0] PI_Q30 = 35'sd3373259426;

    // atan(2^-i) in Q30
    localparam logic [29:0] ATAN_Q30 [CORDIC_N] = '{
        30'd843314857, 30'd497837829, 30'd263043837, 30'd133525159, 30'd67021687,
        30'd33543516, 30'd16775851, 30'd8388437, 30'd4194283, 30'd2097149,
        30'd1048576, 30'd524288, 30'd262144, 30'd131072, 30'd65536, 30'd32768,
        30'd16384, 30'd8192, 30'd4096, 30'd2048, 30'd1024, 30'd512, 30'd256,
        30'd128, 30'd64, 30'd32, 30'd16, 30'd8, 30'd4, 30'd2
    };

    // per-item control that travels with the data
    typedef struct packed {
        logic              valid;
        logic [2:0]        cmd;
        logic [15:0]       re;
        logic [15:0]       im;
        logic              sat;
        logic              dz;
        logic [1:0]        neg;
        logic [1:0]        clip;
    } t_meta;

    // saturated value and its flag
    typedef struct packed {
        logic [15:0] val;
        logic        flag;
    } t_sat;

    // sign and magnitude to a saturated 16-bit value
    function automatic t_sat sat_mag(input logic neg, input logic [31:0] mag);
        t_sat r;
        r.flag = 1'b0;
        if (!neg && mag > 32'd32767) begin
            r.val  = 16'h7fff;
            r.flag = 1'b1;
        end else if (neg && mag > 32'd32768) begin
            r.val  = 16'h8000;
            r.flag = 1'b1;
        end else if (neg) begin
            r.val = 16'(-mag[15:0]);
        end else begin
            r.val = mag[15:0];
        end
        return r;
    endfunction

endpackage
`default_nettype wire

/* sv/complex_arithmetic_unit_core.sv */
// complex arithmetic unit: add, sub, mul, div, magnitude and phase in one pipeline
//
//  channel   signals                                   handshake
//  input     i_command, i_a_real/imag, i_b_real/imag   start high while busy low
//  result    o_out_real, o_out_imag, o_status          o_strobe for one cycle
//
// one item enters every cycle; busy stays low, nothing ever waits
// each result appears once its item has passed the longest path:
// an input register, products, sums, a divider setup stage, 29 restoring divider
// steps and a final rounding stage (the 30-step cordic and 16-step root run alongside)
// synchronous active-low reset clears the valid bits of every stage
`default_nettype none
module complex_arithmetic_unit_core (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 start,
    output logic                      busy,
    input  wire logic [2:0]           i_command,
    input  wire logic signed [15:0]   i_a_real,
    input  wire logic signed [15:0]   i_a_imag,
    input  wire logic signed [15:0]   i_b_real,
    input  wire logic signed [15:0]   i_b_imag,
    output logic                      o_strobe,
    output logic signed [15:0]        o_out_real,
    output logic signed [15:0]        o_out_imag,
    output logic [1:0]                o_status
);
    import cau_pkg::*;

    // input register
    logic              r_v0;
    logic [2:0]        r_cmd0;
    logic signed [15:0] r_ar0, r_ai0, r_br0, r_bi0;

    // item control per stage
    t_meta r_meta [1:ST_LAST];

    // products
    logic signed [31:0] r_prr, r_pii, r_pri, r_pir;
    logic signed [31:0] r_paa, r_pai, r_pbb, r_pbi;

    // sums
    logic signed [32:0] r_mre, r_mim;
    logic signed [32:0] r_dn [2];
    logic [31:0]        r_d;

    // divider lanes
    logic [31:0] r_drem [2][ST_MUL:ST_LAST-1];
    logic [28:0] r_dnb  [2][ST_MUL:ST_LAST-1];
    logic [28:0] r_dq   [2][ST_MUL:ST_LAST-1];
    logic [31:0] r_dd   [ST_MUL:ST_LAST-1];

    // square root
    logic [31:0] r_ss [2:ST_SQRT-1];
    logic [31:0] r_sr [2:ST_SQRT-1];

    // cordic
    logic signed [63:0] r_cx [1:ST_CORDIC-1];
    logic signed [63:0] r_cy [1:ST_CORDIC-1];
    logic signed [34:0] r_cz [1:ST_CORDIC-1];

    assign busy = 1'b0;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
        end else begin
            r_v0 <= start;
        end
        r_cmd0 <= i_command;
        r_ar0  <= i_a_real;
        r_ai0  <= i_a_imag;
        r_br0  <= i_b_real;
        r_bi0  <= i_b_imag;
    end

    // stage 1: add/sub results, products, cordic prerotation
    logic signed [16:0] as_re, as_im;
    logic [16:0]        as_mre, as_mim;
    t_sat               as_sre, as_sim;
    t_meta              n_meta1;
    logic signed [63:0] n_cx, n_cy;
    logic signed [34:0] n_cz;

    always_comb begin
        if (r_cmd0 == CMD_SUB) begin
            as_re = 17'(r_ar0) - 17'(r_br0);
            as_im = 17'(r_ai0) - 17'(r_bi0);
        end else begin
            as_re = 17'(r_ar0) + 17'(r_br0);
            as_im = 17'(r_ai0) + 17'(r_bi0);
        end
        as_mre = as_re[16] ? 17'(-as_re) : 17'(as_re);
        as_mim = as_im[16] ? 17'(-as_im) : 17'(as_im);
        as_sre = sat_mag(as_re[16], {15'd0, as_mre});
        as_sim = sat_mag(as_im[16], {15'd0, as_mim});
        n_meta1       = '0;
        n_meta1.valid = r_v0;
        n_meta1.cmd   = r_cmd0;
        if (r_cmd0 == CMD_ADD || r_cmd0 == CMD_SUB) begin
            n_meta1.re  = as_sre.val;
            n_meta1.im  = as_sim.val;
            n_meta1.sat = as_sre.flag | as_sim.flag;
        end
        n_cx = {{4{r_ar0[15]}}, r_ar0, 44'd0};
        n_cy = {{4{r_ai0[15]}}, r_ai0, 44'd0};
        n_cz = '0;
        if (r_ar0[15]) begin
            n_cx = -n_cx;
            n_cy = -n_cy;
            n_cz = r_ai0[15] ? -PI_Q30 : PI_Q30;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_meta[1] <= '0;
        end else begin
            r_meta[1] <= n_meta1;
        end
        r_prr <= r_ar0 * r_br0;
        r_pii <= r_ai0 * r_bi0;
        r_pri <= r_ar0 * r_bi0;
        r_pir <= r_ai0 * r_br0;
        r_paa <= r_ar0 * r_ar0;
        r_pai <= r_ai0 * r_ai0;
        r_pbb <= r_br0 * r_br0;
        r_pbi <= r_bi0 * r_bi0;
        r_cx[1] <= n_cx;
        r_cy[1] <= n_cy;
        r_cz[1] <= n_cz;
    end

    // stage 2: sums of products
    always_ff @(posedge i_clk) begin
        r_mre    <= 33'(r_prr) - 33'(r_pii);
        r_mim    <= 33'(r_pri) + 33'(r_pir);
        r_dn[0]  <= 33'(r_prr) + 33'(r_pii);
        r_dn[1]  <= 33'(r_pir) - 33'(r_pri);
        r_d      <= $unsigned(r_pbb) + $unsigned(r_pbi);
        r_ss[2]  <= $unsigned(r_paa) + $unsigned(r_pai);
        r_sr[2]  <= '0;
    end

    // stage 3: multiply rounding, divider setup
    logic [32:0] mul_mre, mul_mim;
    logic [32:0] mul_rre, mul_rim;
    t_sat        mul_sre, mul_sim;
    logic [32:0] dv_abs  [2];
    logic [47:0] dv_lim;
    logic [1:0]  dv_clip;

    always_comb begin
        mul_mre = r_mre[32] ? 33'(-r_mre) : 33'(r_mre);
        mul_mim = r_mim[32] ? 33'(-r_mim) : 33'(r_mim);
        mul_rre = (mul_mre + 33'd2048) >> FRAC_W;
        mul_rim = (mul_mim + 33'd2048) >> FRAC_W;
        mul_sre = sat_mag(r_mre[32], mul_rre[31:0]);
        mul_sim = sat_mag(r_mim[32], mul_rim[31:0]);
        dv_lim  = {1'b0, r_d, 15'd0} + {16'd0, r_d};
        for (int l = 0; l < 2; l++) begin
            dv_abs[l]  = r_dn[l][32] ? 33'(-r_dn[l]) : 33'(r_dn[l]);
            dv_clip[l] = {16'd0, dv_abs[l][31:0]} >= dv_lim;
        end
    end

    // divider lane setup
    always_ff @(posedge i_clk) begin
        for (int l = 0; l < 2; l++) begin
            r_drem[l][ST_MUL] <= {16'd0, dv_abs[l][31:16]};
            r_dnb[l][ST_MUL]  <= {dv_abs[l][15:0], 13'd0};
            r_dq[l][ST_MUL]   <= '0;
        end
        r_dd[ST_MUL] <= r_d;
    end

    // item control delay line with results merged at their stages
    genvar k;
    generate
        for (k = 2; k <= ST_LAST; k++) begin : g_meta
            t_meta n_meta;
            logic [34:0] cz_m, cz_r;
            logic [31:0] sq_r;
            logic [28:0] dq_r [2];
            t_sat        fin  [2];
            always_comb begin
                n_meta = r_meta[k-1];
                cz_m = '0;
                cz_r = '0;
                sq_r = '0;
                for (int l = 0; l < 2; l++) begin
                    dq_r[l] = '0;
                    fin[l]  = '0;
                end
                if (k == ST_MUL) begin
                    if (n_meta.cmd == CMD_MUL) begin
                        n_meta.re  = mul_sre.val;
                        n_meta.im  = mul_sim.val;
                        n_meta.sat = mul_sre.flag | mul_sim.flag;
                    end
                    if (n_meta.cmd == CMD_DIV) begin
                        n_meta.dz   = (r_d == 32'd0);
                        n_meta.neg  = {r_dn[1][32], r_dn[0][32]};
                        n_meta.clip = dv_clip;
                    end
                end
                if (k == ST_SQRT && n_meta.cmd == CMD_MAG) begin
                    sq_r = r_sr[ST_SQRT-1]
                        + {31'd0, (r_ss[ST_SQRT-1] > r_sr[ST_SQRT-1])};
                    fin[0]     = sat_mag(1'b0, sq_r);
                    n_meta.re  = fin[0].val;
                    n_meta.im  = '0;
                    n_meta.sat = fin[0].flag;
                end
                if (k == ST_CORDIC && n_meta.cmd == CMD_PHASE) begin
                    cz_m = r_cz[ST_CORDIC-1][34] ? 35'(-r_cz[ST_CORDIC-1])
                                                 : 35'(r_cz[ST_CORDIC-1]);
                    cz_r = (cz_m + 35'd131072) >> (30 - FRAC_W);
                    fin[0]     = sat_mag(r_cz[ST_CORDIC-1][34], cz_r[31:0]);
                    n_meta.re  = fin[0].val;
                    n_meta.im  = '0;
                    n_meta.sat = fin[0].flag;
                end
                if (k == ST_LAST && n_meta.cmd == CMD_DIV) begin
                    for (int l = 0; l < 2; l++) begin
                        dq_r[l] = 29'((30'(r_dq[l][ST_LAST-1]) + 30'd1) >> 1);
                        fin[l]  = sat_mag(n_meta.neg[l],
                                          n_meta.clip[l] ? 32'd32769 : {3'd0, dq_r[l]});
                    end
                    if (n_meta.dz) begin
                        n_meta.re  = '0;
                        n_meta.im  = '0;
                        n_meta.sat = 1'b0;
                    end else begin
                        n_meta.re  = fin[0].val;
                        n_meta.im  = fin[1].val;
                        n_meta.sat = fin[0].flag | fin[1].flag;
                    end
                end
            end
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_meta[k] <= '0;
                end else begin
                    r_meta[k] <= n_meta;
                end
            end
        end
    endgenerate

    // restoring divider, one quotient bit per stage
    generate
        for (k = ST_MUL + 1; k <= ST_LAST - 1; k++) begin : g_div
            logic [31:0] t [2];
            logic [31:0] n_rem [2];
            logic [28:0] n_q [2];
            always_comb begin
                for (int l = 0; l < 2; l++) begin
                    t[l] = {r_drem[l][k-1][30:0], r_dnb[l][k-1][28]};
                    if (t[l] >= r_dd[k-1]) begin
                        n_rem[l] = t[l] - r_dd[k-1];
                        n_q[l]   = {r_dq[l][k-1][27:0], 1'b1};
                    end else begin
                        n_rem[l] = t[l];
                        n_q[l]   = {r_dq[l][k-1][27:0], 1'b0};
                    end
                end
            end
            always_ff @(posedge i_clk) begin
                for (int l = 0; l < 2; l++) begin
                    r_drem[l][k] <= n_rem[l];
                    r_dq[l][k]   <= n_q[l];
                    r_dnb[l][k]  <= {r_dnb[l][k-1][27:0], 1'b0};
                end
                r_dd[k] <= r_dd[k-1];
            end
        end
    endgenerate

    // integer square root, one result bit per stage
    generate
        for (k = 3; k <= ST_SQRT - 1; k++) begin : g_sqrt
            localparam logic [31:0] BIT = 32'd1 << (30 - 2 * (k - 3));
            logic [31:0] trial;
            always_ff @(posedge i_clk) begin
                if (r_ss[k-1] >= trial) begin
                    r_ss[k] <= r_ss[k-1] - trial;
                    r_sr[k] <= (r_sr[k-1] >> 1) + BIT;
                end else begin
                    r_ss[k] <= r_ss[k-1];
                    r_sr[k] <= r_sr[k-1] >> 1;
                end
            end
            assign trial = r_sr[k-1] + BIT;
        end
    endgenerate

    // cordic vectoring, one micro-rotation per stage
    generate
        for (k = 2; k <= ST_CORDIC - 1; k++) begin : g_cordic
            localparam int SH = k - 2;
            logic signed [34:0] ang;
            assign ang = 35'({5'd0, ATAN_Q30[SH]});
            always_ff @(posedge i_clk) begin
                if (r_cy[k-1] == 64'sd0) begin
                    r_cx[k] <= r_cx[k-1];
                    r_cy[k] <= r_cy[k-1];
                    r_cz[k] <= r_cz[k-1];
                end else if (!r_cy[k-1][63]) begin
                    r_cx[k] <= r_cx[k-1] + (r_cy[k-1] >>> SH);
                    r_cy[k] <= r_cy[k-1] - (r_cx[k-1] >>> SH);
                    r_cz[k] <= r_cz[k-1] + ang;
                end else begin
                    r_cx[k] <= r_cx[k-1] - (r_cy[k-1] >>> SH);
                    r_cy[k] <= r_cy[k-1] + (r_cx[k-1] >>> SH);
                    r_cz[k] <= r_cz[k-1] - ang;
                end
            end
        end
    endgenerate

    // result ports
    assign o_strobe   = r_meta[ST_LAST].valid;
    assign o_out_real = r_meta[ST_LAST].re;
    assign o_out_imag = r_meta[ST_LAST].im;
    assign o_status   = r_meta[ST_LAST].sat ? STAT_SAT :
                        (r_meta[ST_LAST].dz ? STAT_DZ : STAT_OK);

    // every item comes out after a fixed latency
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start |-> ##34 o_strobe)
        else $error("item lost in pipeline");

    // divide by zero gives zero parts
    a_dz_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_status == STAT_DZ) |-> (o_out_real == 16'd0 && o_out_imag == 16'd0))
        else $error("nonzero result on divide by zero");

    // magnitude and phase have no imaginary part
    a_scalar_imag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && (r_meta[ST_LAST].cmd == CMD_MAG || r_meta[ST_LAST].cmd == CMD_PHASE))
        |-> (o_out_imag == 16'd0 && o_status != STAT_DZ))
        else $error("scalar result with imaginary part");

endmodule
`default_nettype wire
